FILE: hdl/tist_pkg.sv
`timescale 1ns / 1ps

package tist_pkg;

  localparam int STAMP_W   = 63;
  localparam int STATUS_W  = 17;
  localparam int HELD_W    = 13;
  localparam int TEL_W     = 3;
  localparam int DIGIT_W   = 4;
  localparam int LEVEL_W   = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic {
    MODE_APPEND = 1'b0,
    MODE_QUERY  = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    OUT_HIT          = 3'd0,
    OUT_BEFORE_FIRST = 3'd1,
    OUT_AFTER_LAST   = 3'd2,
    OUT_EMPTY        = 3'd3,
    OUT_APPENDED     = 3'd4,
    OUT_FULL_DROPPED = 3'd5
  } outcome_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CLOUD_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 1'b1;

  localparam logic signed [LEVEL_W-1:0] CLOUD_LIMIT_RST = -16'sd19200;
  localparam logic signed [LEVEL_W-1:0] ANGLE_LIMIT_RST = 16'sd7680;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APP_CHK,
    ST_FIRST,
    ST_LAST,
    ST_SEARCH,
    ST_SCAN,
    ST_STATUS
  } state_e;

  typedef struct packed {
    mode_e                     mode;
    logic [TEL_W-1:0]          telescope;
    logic [STAMP_W-1:0]        stamp_value;
    logic [DIGIT_W-1:0]        daq_digit;
    logic [DIGIT_W-1:0]        slow_control_digit;
    logic [DIGIT_W-1:0]        temperature_digit;
    logic signed [LEVEL_W-1:0] cloud_level;
    logic signed [LEVEL_W-1:0] tilt_angle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status_word;
    outcome_e            outcome;
    logic [HELD_W-1:0]   entries_held;
  } rsp_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [STATUS_W-1:0] status;
  } entry_t;

endpackage

FILE: hdl/timestamp_interval_status_table_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// request   in         start & !busy          req_i  (tist_pkg::req_t)
// result    out        done_o, one cycle      rsp_o  (tist_pkg::rsp_t)
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// One request at a time; busy stays high from acceptance until the result.
// Append: an empty or full table needs no read; otherwise the last stamp is
// read first to track whether the table is still in ascending order.
// Query on an ordered table: a binary search with one registered memory
// read per step; a table appended out of order is scanned linearly.
// rst_ni clears all counts, marks every table ordered and restores the
// default limits; the store itself is not cleared.
// The result strobe cannot be stalled; a new request may start in its cycle.
module timestamp_interval_status_table_core #(
  parameter int TABLE_DEPTH = 4096,
  parameter int UNIT_COUNT  = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  tist_pkg::req_t                      req_i,
  output logic                                done_o,
  output tist_pkg::rsp_t                      rsp_o,
  input  logic                                cfg_we_i,
  input  logic [tist_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tist_pkg::LEVEL_W-1:0]        cfg_data_i
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int UW = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
  localparam int AW = UW + IW;
  localparam logic [4:0]    UNIT_LIM = 5'(UNIT_COUNT);
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);

  tist_pkg::state_e state_q, state_d;
  tist_pkg::req_t   req_q;
  tist_pkg::rsp_t   rsp_q, rsp_d;
  logic             done_q, done_d;

  logic signed [tist_pkg::LEVEL_W-1:0] cloud_lim_q, angle_lim_q;

  logic [CW-1:0] cnt_q [UNIT_COUNT];
  logic [UNIT_COUNT-1:0] sorted_q;

  logic [UW-1:0] unit_q;
  logic          unit_ok_q;
  logic [CW-1:0] n_q, n_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic          prev_le_q, prev_le_d;

  logic cnt_inc, clr_sorted;

  // Memory interface.
  tist_pkg::mem_ctl_t mem_ctl;
  logic [IW-1:0]      ridx, widx;
  tist_pkg::entry_t   wdata, rdata;

  // ------------------------------------------------------------------
  // Shared datapath values
  // ------------------------------------------------------------------
  logic [CW-1:0]                n_cur;
  logic                         full;
  logic                         lt;
  logic                         sorted_cur;
  logic [IW-1:0]                last_idx, lo_n, hi_n, mid_n;
  logic [IW:0]                  mid_sum;
  logic                         span_gt1;
  logic [tist_pkg::STATUS_W-1:0] status_w;

  function automatic logic [tist_pkg::STATUS_W-1:0] sat9(
    input logic [tist_pkg::DIGIT_W-1:0] d
  );
    return (d > 4'd9) ? 17'd9 : tist_pkg::STATUS_W'(d);
  endfunction

  always_comb begin
    status_w = sat9(req_q.daq_digit) * 17'd10000
             + sat9(req_q.slow_control_digit) * 17'd1000
             + sat9(req_q.temperature_digit) * 17'd100;
    if (req_q.cloud_level < cloud_lim_q) begin
      status_w = status_w + 17'd10;
    end
    if (req_q.tilt_angle > angle_lim_q) begin
      status_w = status_w + 17'd1;
    end
  end

  assign n_cur      = unit_ok_q ? cnt_q[unit_q] : '0;
  assign full       = (n_cur >= DEPTH_C);
  assign sorted_cur = sorted_q[unit_q];
  // The one shared 63-bit comparator: request stamp against the stamp read.
  assign lt         = (req_q.stamp_value < rdata.stamp);
  assign last_idx   = IW'(n_q - CW'(1));
  // Keep stamp[lo] <= time < stamp[hi].
  assign lo_n       = lt ? lo_q : mid_q;
  assign hi_n       = lt ? mid_q : hi_q;
  assign span_gt1   = (hi_n - lo_n) > IW'(1);
  assign mid_sum    = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n      = mid_sum[IW:1];

  // ------------------------------------------------------------------
  // Next state and sequencer registers
  // ------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    n_d        = n_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    prev_le_d  = prev_le_q;
    cnt_inc    = 1'b0;
    clr_sorted = 1'b0;
    case (state_q)
      tist_pkg::ST_IDLE: begin
        if (start) begin
          state_d = tist_pkg::ST_DECODE;
        end
      end
      tist_pkg::ST_DECODE: begin
        n_d = n_cur;
        if (req_q.mode == tist_pkg::MODE_APPEND) begin
          if (!unit_ok_q || full) begin
            rsp_d   = '{status_word: status_w, outcome: tist_pkg::OUT_FULL_DROPPED,
                        entries_held: tist_pkg::HELD_W'(n_cur)};
            done_d  = 1'b1;
            state_d = tist_pkg::ST_IDLE;
          end else if (n_cur == '0) begin
            cnt_inc = 1'b1;
            rsp_d   = '{status_word: status_w, outcome: tist_pkg::OUT_APPENDED,
                        entries_held: tist_pkg::HELD_W'(n_cur + CW'(1))};
            done_d  = 1'b1;
            state_d = tist_pkg::ST_IDLE;
          end else begin
            state_d = tist_pkg::ST_APP_CHK;
          end
        end else begin
          if (n_cur == '0) begin
            rsp_d   = '{status_word: '0, outcome: tist_pkg::OUT_EMPTY,
                        entries_held: tist_pkg::HELD_W'(n_cur)};
            done_d  = 1'b1;
            state_d = tist_pkg::ST_IDLE;
          end else begin
            state_d = tist_pkg::ST_FIRST;
          end
        end
      end
      tist_pkg::ST_APP_CHK: begin
        // A stamp below the last one breaks ascending order for good.
        clr_sorted = lt;
        cnt_inc    = 1'b1;
        rsp_d      = '{status_word: status_w, outcome: tist_pkg::OUT_APPENDED,
                       entries_held: tist_pkg::HELD_W'(n_q + CW'(1))};
        done_d     = 1'b1;
        state_d    = tist_pkg::ST_IDLE;
      end
      tist_pkg::ST_FIRST: begin
        if (lt) begin
          rsp_d   = '{status_word: '0, outcome: tist_pkg::OUT_BEFORE_FIRST,
                      entries_held: tist_pkg::HELD_W'(n_q)};
          done_d  = 1'b1;
          state_d = tist_pkg::ST_IDLE;
        end else begin
          state_d = tist_pkg::ST_LAST;
        end
      end
      tist_pkg::ST_LAST: begin
        if (!lt) begin
          rsp_d   = '{status_word: '0, outcome: tist_pkg::OUT_AFTER_LAST,
                      entries_held: tist_pkg::HELD_W'(n_q)};
          done_d  = 1'b1;
          state_d = tist_pkg::ST_IDLE;
        end else if (sorted_cur) begin
          lo_d  = '0;
          hi_d  = last_idx;
          mid_d = last_idx >> 1;
          if (last_idx > IW'(1)) begin
            state_d = tist_pkg::ST_SEARCH;
          end else begin
            state_d = tist_pkg::ST_STATUS;
          end
        end else begin
          lo_d      = '0;
          mid_d     = IW'(1);
          prev_le_d = 1'b1;
          state_d   = tist_pkg::ST_SCAN;
        end
      end
      tist_pkg::ST_SEARCH: begin
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = mid_n;
        if (!span_gt1) begin
          state_d = tist_pkg::ST_STATUS;
        end
      end
      tist_pkg::ST_SCAN: begin
        if (prev_le_q && lt) begin
          state_d = tist_pkg::ST_STATUS;
        end else if (mid_q == last_idx) begin
          rsp_d   = '{status_word: '0, outcome: tist_pkg::OUT_AFTER_LAST,
                      entries_held: tist_pkg::HELD_W'(n_q)};
          done_d  = 1'b1;
          state_d = tist_pkg::ST_IDLE;
        end else begin
          prev_le_d = !lt;
          lo_d      = mid_q;
          mid_d     = mid_q + IW'(1);
        end
      end
      tist_pkg::ST_STATUS: begin
        rsp_d   = '{status_word: rdata.status, outcome: tist_pkg::OUT_HIT,
                    entries_held: tist_pkg::HELD_W'(n_q)};
        done_d  = 1'b1;
        state_d = tist_pkg::ST_IDLE;
      end
      default: begin
        state_d = tist_pkg::ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Memory port controls
  // ------------------------------------------------------------------
  always_comb begin
    mem_ctl = '0;
    ridx    = '0;
    widx    = '0;
    case (state_q)
      tist_pkg::ST_DECODE: begin
        if (req_q.mode == tist_pkg::MODE_APPEND) begin
          if (unit_ok_q && !full) begin
            if (n_cur == '0) begin
              mem_ctl.wr_en = 1'b1;
            end else begin
              mem_ctl.rd_en = 1'b1;
              ridx          = IW'(n_cur - CW'(1));
            end
          end
        end else if (n_cur != '0) begin
          mem_ctl.rd_en = 1'b1;
        end
      end
      tist_pkg::ST_APP_CHK: begin
        mem_ctl.wr_en = 1'b1;
        widx          = n_q[IW-1:0];
      end
      tist_pkg::ST_FIRST: begin
        mem_ctl.rd_en = !lt;
        ridx          = last_idx;
      end
      tist_pkg::ST_LAST: begin
        mem_ctl.rd_en = lt;
        if (sorted_cur) begin
          ridx = (last_idx > IW'(1)) ? (last_idx >> 1) : '0;
        end else begin
          ridx = IW'(1);
        end
      end
      tist_pkg::ST_SEARCH: begin
        mem_ctl.rd_en = 1'b1;
        ridx          = span_gt1 ? mid_n : lo_n;
      end
      tist_pkg::ST_SCAN: begin
        if (prev_le_q && lt) begin
          mem_ctl.rd_en = 1'b1;
          ridx          = lo_q;
        end else if (mid_q != last_idx) begin
          mem_ctl.rd_en = 1'b1;
          ridx          = mid_q + IW'(1);
        end
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  assign wdata = '{stamp: req_q.stamp_value, status: status_w};

  tist_store #(
    .AW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i ({unit_q, widx}),
    .wdata_i (wdata),
    .raddr_i ({unit_q, ridx}),
    .rdata_o (rdata)
  );

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tist_pkg::ST_IDLE;
      done_q    <= 1'b0;
      sorted_q  <= '1;
      cloud_lim_q <= tist_pkg::CLOUD_LIMIT_RST;
      angle_lim_q <= tist_pkg::ANGLE_LIMIT_RST;
      for (int u = 0; u < UNIT_COUNT; u++) begin
        cnt_q[u] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cnt_inc) begin
        cnt_q[unit_q] <= n_cur + CW'(1);
      end
      if (clr_sorted) begin
        sorted_q[unit_q] <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tist_pkg::REG_CLOUD_LIMIT: cloud_lim_q <= cfg_data_i;
          tist_pkg::REG_ANGLE_LIMIT: angle_lim_q <= cfg_data_i;
          default: begin
            cloud_lim_q <= cloud_lim_q;
          end
        endcase
      end
    end
  end

  // Payload and search pointers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q     <= req_i;
      unit_q    <= UW'(req_i.telescope);
      unit_ok_q <= ({2'b00, req_i.telescope} < UNIT_LIM);
    end
    rsp_q     <= rsp_d;
    n_q       <= n_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    prev_le_q <= prev_le_d;
  end

  assign busy   = (state_q != tist_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  // A result only follows a request that was in flight.
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q != tist_pkg::ST_IDLE))
    else $error("result strobe without a request in flight");

  // An accepted request always makes the block busy next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Binary search probe stays strictly inside its bracket.
  a_search_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tist_pkg::ST_SEARCH) |-> (lo_q < mid_q && mid_q < hi_q))
    else $error("search probe outside bracket");

  // A table never holds more than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tist_pkg::ST_IDLE && unit_ok_q) |-> (n_cur <= DEPTH_C))
    else $error("entry count above table depth");
`endif

endmodule

FILE: hdl/tist_store.sv
`timescale 1ns / 1ps

module tist_store #(
  parameter int AW = 15
) (
  input  logic              clk_i,
  input  tist_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     waddr_i,
  input  tist_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output tist_pkg::entry_t  rdata_o
);

  tist_pkg::entry_t mem [2**AW];
  tist_pkg::entry_t rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/timestamp_interval_status_table_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the per-telescope status table: appends build packed
// status words, queries look up the interval a time falls into. Every accepted
// request is run through a local table model and the predicted result is queued;
// every result strobe is checked against the oldest queued prediction.
module timestamp_interval_status_table_core_tb;
  import tist_pkg::*;

  localparam int TABLE_DEPTH = 4096;
  localparam int UNIT_COUNT  = 6;
  // Slowest legal request is a linear scan of a full unordered table plus the
  // longest sender gap; allow several times that with nothing moving.
  localparam int QUIET_LIMIT = 25000;
  localparam int BURST_LEN   = 32;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  req_t                 req_i      = '0;
  logic                 done_o;
  rsp_t                 rsp_o;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [LEVEL_W-1:0]   cfg_data_i = '0;

  // Local copy of the tables and the limits.
  logic [STAMP_W-1:0]        held_stamp  [UNIT_COUNT][TABLE_DEPTH];
  logic [STATUS_W-1:0]       held_status [UNIT_COUNT][TABLE_DEPTH];
  int unsigned               held_count  [UNIT_COUNT];
  logic signed [LEVEL_W-1:0] cloud_lim;
  logic signed [LEVEL_W-1:0] angle_lim;

  rsp_t awaited_rsp [$];
  rsp_t head_rsp;
  int   err_count    = 0;
  int   quiet_cycles = 0;
  bit   no_idle      = 1'b0;   // burst stretches: sender never pauses
  bit   start_held   = 1'b0;   // start left high after the last request

  timestamp_interval_status_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .UNIT_COUNT (UNIT_COUNT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned digit_sat(input logic [DIGIT_W-1:0] d);
    return (d > 4'd9) ? 9 : d;
  endfunction

  // Compute the result of one request and apply it to the local tables.
  task automatic lookup_or_append(input req_t r, output rsp_t res);
    int unsigned u;
    int unsigned n;
    int unsigned stat;
    bit          unit_ok;
    bit          found;
    u       = r.telescope;
    unit_ok = (u < UNIT_COUNT);
    n       = unit_ok ? held_count[u] : 0;
    found   = 1'b0;
    res     = '0;
    res.entries_held = HELD_W'(n);
    if (r.mode == MODE_APPEND) begin
      stat = digit_sat(r.daq_digit) * 10000 + digit_sat(r.slow_control_digit) * 1000
           + digit_sat(r.temperature_digit) * 100;
      if ($signed(r.cloud_level) < cloud_lim) stat += 10;
      if ($signed(r.tilt_angle) > angle_lim) stat += 1;
      res.status_word = STATUS_W'(stat);
      if (!unit_ok || n >= TABLE_DEPTH) begin
        // Out-of-range unit or full table: drop, but still report the word.
        res.outcome = OUT_FULL_DROPPED;
      end else begin
        held_stamp[u][n]  = r.stamp_value;
        held_status[u][n] = STATUS_W'(stat);
        held_count[u]     = n + 1;
        res.outcome       = OUT_APPENDED;
        res.entries_held  = HELD_W'(n + 1);
      end
    end else if (n == 0) begin
      res.outcome = OUT_EMPTY;
    end else if (r.stamp_value < held_stamp[u][0]) begin
      res.outcome = OUT_BEFORE_FIRST;
    end else if (r.stamp_value >= held_stamp[u][n-1]) begin
      res.outcome = OUT_AFTER_LAST;
    end else begin
      // First bracketing pair wins; this also covers tables appended out of order.
      res.outcome = OUT_AFTER_LAST;
      for (int unsigned i = 0; i + 1 < n && !found; i++) begin
        if (r.stamp_value >= held_stamp[u][i] && r.stamp_value < held_stamp[u][i+1]) begin
          res.status_word = held_status[u][i];
          res.outcome     = OUT_HIT;
          found           = 1'b1;
        end
      end
    end
  endtask

  function automatic req_t make_req(input mode_e m, input logic [TEL_W-1:0] unit,
                                    input logic [STAMP_W-1:0] stamp,
                                    input logic [DIGIT_W-1:0] daq,
                                    input logic [DIGIT_W-1:0] slow,
                                    input logic [DIGIT_W-1:0] temp,
                                    input logic signed [LEVEL_W-1:0] cloud,
                                    input logic signed [LEVEL_W-1:0] tilt);
    req_t r;
    r.mode               = m;
    r.telescope          = unit;
    r.stamp_value        = stamp;
    r.daq_digit          = daq;
    r.slow_control_digit = slow;
    r.temperature_digit  = temp;
    r.cloud_level        = cloud;
    r.tilt_angle         = tilt;
    return r;
  endfunction

  // Hold a request on the port until it is taken, queue its prediction, then
  // draw the gap before the next one.
  task automatic send_request(input req_t r);
    rsp_t        want;
    int unsigned gap;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    lookup_or_append(r, want);
    awaited_rsp = {awaited_rsp, want};
    gap        = no_idle ? 0 : $urandom_range(0, 18);
    start_held = (gap == 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic append_entry(input int unsigned unit, input logic [STAMP_W-1:0] stamp,
                              input logic [DIGIT_W-1:0] daq, input logic [DIGIT_W-1:0] slow,
                              input logic [DIGIT_W-1:0] temp,
                              input logic signed [LEVEL_W-1:0] cloud,
                              input logic signed [LEVEL_W-1:0] tilt);
    send_request(make_req(MODE_APPEND, TEL_W'(unit), stamp, daq, slow, temp, cloud, tilt));
  endtask

  task automatic query_at(input int unsigned unit, input logic [STAMP_W-1:0] stamp);
    send_request(make_req(MODE_QUERY, TEL_W'(unit), stamp, '0, '0, '0, '0, '0));
  endtask

  // Drop start and wait until every queued result has come back.
  task automatic drain_results();
    if (start_held) begin
      start      <= 1'b0;
      start_held  = 1'b0;
    end
    while (awaited_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Write both limits on an idle block.
  task automatic set_limits(input logic [LEVEL_W-1:0] cloud, input logic [LEVEL_W-1:0] angle);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CLOUD_LIMIT;
    cfg_data_i <= cloud;
    @(posedge clk_i);
    cloud_lim   = cloud;
    cfg_idx_i  <= REG_ANGLE_LIMIT;
    cfg_data_i <= angle;
    @(posedge clk_i);
    angle_lim   = angle;
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic signed [LEVEL_W-1:0] pick_level(
      input logic signed [LEVEL_W-1:0] lim);
    case ($urandom_range(0, 3))
      0:       return lim - 16'sd1;
      1:       return lim;
      2:       return lim + 16'sd1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // Queries on empty tables and on units past the last one; appends to those
  // units are dropped with outcome full.
  task automatic test_empty_tables();
    query_at(0, '0);
    query_at(3, STAMP_MAX);
    query_at(6, 63'd5);
    query_at(7, STAMP_MAX);
    append_entry(6, 63'd7, 4'd15, 4'd15, 4'd15, -16'sd32768, 16'sd32767);
    append_entry(7, STAMP_MAX, 4'd9, 4'd0, 4'd9, 16'sd0, 16'sd0);
  endtask

  // A single entry: every query is either before it or at/after it.
  task automatic test_single_entry();
    append_entry(1, 63'd1000, 4'd1, 4'd2, 4'd3, 16'sd0, 16'sd0);
    query_at(1, 63'd999);
    query_at(1, 63'd1000);
    query_at(1, '0);
    query_at(1, STAMP_MAX);
  endtask

  // Digit saturation, both limit flags, a duplicate stamp and interval edges.
  task automatic test_status_packing();
    append_entry(2, 63'd0,  4'd15, 4'd15, 4'd15, -16'sd32768, 16'sd32767);
    append_entry(2, 63'd10, 4'd0,  4'd0,  4'd0,  16'sd32767, -16'sd32768);
    append_entry(2, 63'd20, 4'd9,  4'd10, 4'd12, CLOUD_LIMIT_RST, ANGLE_LIMIT_RST + 16'sd1);
    append_entry(2, 63'd20, 4'd3,  4'd4,  4'd5,  CLOUD_LIMIT_RST - 16'sd1, ANGLE_LIMIT_RST);
    query_at(2, 63'd0);
    query_at(2, 63'd9);
    query_at(2, 63'd10);
    query_at(2, 63'd19);
    query_at(2, 63'd20);
  endtask

  // Stamps appended out of order force the linear scan path.
  task automatic test_unordered_table();
    append_entry(5, 63'd300, 4'd1, 4'd1, 4'd1, 16'sd0, 16'sd0);
    append_entry(5, 63'd100, 4'd2, 4'd2, 4'd2, 16'sd0, 16'sd0);
    append_entry(5, 63'd500, 4'd3, 4'd3, 4'd3, 16'sd0, 16'sd0);
    append_entry(5, STAMP_MAX, 4'd4, 4'd4, 4'd4, 16'sd0, 16'sd0);
    query_at(5, 63'd50);
    query_at(5, 63'd350);
    query_at(5, 63'd600);
    query_at(5, STAMP_MAX - 63'd1);
  endtask

  // Limits at both extremes and at zero, checked on the boundary values.
  // Appends go to out-of-range units so no table is touched.
  task automatic test_limit_edges();
    set_limits(16'h7FFF, 16'h8000);
    append_entry(6, '0, 4'd0, 4'd0, 4'd0, 16'sd32766, -16'sd32768);
    append_entry(7, '0, 4'd0, 4'd0, 4'd0, 16'sd32767, -16'sd32767);
    set_limits(16'h8000, 16'h7FFF);
    append_entry(6, '0, 4'd1, 4'd1, 4'd1, -16'sd32768, 16'sd32767);
    set_limits(16'h0000, 16'h0000);
    append_entry(7, '0, 4'd2, 4'd2, 4'd2, -16'sd1, 16'sd1);
    append_entry(6, '0, 4'd2, 4'd2, 4'd2, 16'sd0, 16'sd0);
  endtask

  // Build an ascending table on unit 0 in one back-to-back burst, then probe
  // the binary search at its edges and inside it.
  task automatic test_sorted_search();
    logic [STAMP_W-1:0] s;
    set_limits(CLOUD_LIMIT_RST, ANGLE_LIMIT_RST);
    s       = '0;
    no_idle = 1'b1;
    for (int i = 0; i < BURST_LEN; i++) begin
      s = s + STAMP_W'($urandom_range(1, 1 << 16));
      append_entry(0, s, DIGIT_W'($urandom), DIGIT_W'($urandom), DIGIT_W'($urandom),
                   LEVEL_W'($urandom), LEVEL_W'($urandom));
    end
    no_idle = 1'b0;
    query_at(0, held_stamp[0][BURST_LEN/2]);
    query_at(0, held_stamp[0][3] + 63'd1);
    query_at(0, held_stamp[0][0]);
    query_at(0, held_stamp[0][BURST_LEN-2]);
    query_at(0, held_stamp[0][BURST_LEN-1] - 63'd1);
    query_at(0, '0);
  endtask

  // Mostly ascending appends per unit with queries aimed inside the tables;
  // the rest is out-of-range units, disordered stamps and raw random times.
  task automatic test_random_traffic(input int count, input logic [LEVEL_W-1:0] cloud,
                                     input logic [LEVEL_W-1:0] angle);
    req_t        r;
    int unsigned u;
    int unsigned n;
    int unsigned pick;
    int unsigned idx;
    logic [63:0] w;
    logic [63:0] span;
    bit          disorder;
    set_limits(cloud, angle);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 39) == 0) drain_results();
      pick = $urandom_range(0, 99);
      u    = (pick < 4) ? 0 : (pick < 10) ? $urandom_range(6, 7) : $urandom_range(1, 5);
      n    = (u < UNIT_COUNT) ? held_count[u] : 0;
      w    = {$urandom, $urandom};
      r    = make_req($urandom_range(0, 1) ? MODE_QUERY : MODE_APPEND, TEL_W'(u), w[62:0],
                      DIGIT_W'($urandom_range(0, 15)), DIGIT_W'($urandom_range(0, 15)),
                      DIGIT_W'($urandom_range(0, 15)), pick_level(cloud_lim),
                      pick_level(angle_lim));
      w        = {$urandom, $urandom};
      // Units 4 and 5 take occasional stray stamps; units 1 to 3 stay sorted.
      disorder = (u >= 4) && ($urandom_range(0, 9) == 0);
      if (r.mode == MODE_APPEND && u < UNIT_COUNT && !disorder) begin
        if (n == 0) begin
          r.stamp_value = {u[1:0], 1'b0, w[59:0]};
        end else if ($urandom_range(0, 5) == 0) begin
          r.stamp_value = held_stamp[u][n-1];
        end else begin
          r.stamp_value = held_stamp[u][n-1] + STAMP_W'($urandom_range(1, 1 << 20));
        end
      end else if (r.mode == MODE_QUERY && n > 0) begin
        idx = $urandom_range(0, n - 1);
        case ($urandom_range(0, 7))
          0: r.stamp_value = '0;
          1: r.stamp_value = STAMP_MAX;
          2: r.stamp_value = held_stamp[u][idx];
          3: r.stamp_value = held_stamp[u][idx] - 63'd1;
          4: ;  // keep the raw random time
          default: begin
            if (held_stamp[u][n-1] > held_stamp[u][0]) begin
              span          = held_stamp[u][n-1] - held_stamp[u][0];
              r.stamp_value = held_stamp[u][0] + STAMP_W'(w % span);
            end else begin
              r.stamp_value = held_stamp[u][idx];
            end
          end
        endcase
      end
      send_request(r);
    end
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_rsp.size() == 0) begin
        $error("unexpected result: status_word %0d outcome %0d entries_held %0d",
               rsp_o.status_word, rsp_o.outcome, rsp_o.entries_held);
        err_count++;
      end else begin
        head_rsp = awaited_rsp.pop_front();
        if (rsp_o.status_word !== head_rsp.status_word) begin
          $error("status_word: expected %0d, got %0d", head_rsp.status_word,
                 rsp_o.status_word);
          err_count++;
        end
        if (rsp_o.outcome !== head_rsp.outcome) begin
          $error("outcome: expected %0d, got %0d", head_rsp.outcome, rsp_o.outcome);
          err_count++;
        end
        if (rsp_o.entries_held !== head_rsp.entries_held) begin
          $error("entries_held: expected %0d, got %0d", head_rsp.entries_held,
                 rsp_o.entries_held);
          err_count++;
        end
      end
    end
  end

  // Count cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timestamp_interval_status_table_core regression: fail");
      $finish;
    end
  end

  initial begin
    cloud_lim = CLOUD_LIMIT_RST;
    angle_lim = ANGLE_LIMIT_RST;
    for (int u = 0; u < UNIT_COUNT; u++) held_count[u] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks run on the reset limits first.
    test_empty_tables();
    test_single_entry();
    test_status_packing();
    test_unordered_table();
    test_limit_edges();
    test_sorted_search();

    test_random_traffic(110, CLOUD_LIMIT_RST, ANGLE_LIMIT_RST);
    test_random_traffic(90, LEVEL_W'($urandom), LEVEL_W'($urandom));
    test_random_traffic(90, 16'h8000, 16'h7FFF);
    test_random_traffic(90, 16'h7FFF, 16'h8000);

    drain_results();
    // Leave room for a stray strobe after the last expected result.
    repeat (64) @(posedge clk_i);
    if (err_count == 0) begin
      $display("timestamp_interval_status_table_core regression: pass");
    end else begin
      $display("timestamp_interval_status_table_core regression: fail");
    end
    $finish;
  end

endmodule
